// ===== rtl/core/frc_pkg.sv =====
// frc_pkg: shared constants, types and state codes of the ring fir filter
`timescale 1ns / 1ps
package frc_pkg;

  localparam int TAPS       = 32;
  localparam int TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SMP_W      = 16;
  localparam int COEF_W     = 16;
  localparam int IDX_W      = 5;
  localparam int PROD_W     = SMP_W + COEF_W;
  localparam int ACC_W      = PROD_W + TAP_W + 1;
  localparam int FRAC_W     = 15;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } frc_state_e;

  typedef struct packed {
    logic shift;   // move samples one cell toward the head
    logic rotate;  // move coefficients one cell toward the head
  } cell_ctl_t;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic mul_en;  // multiply the head cell this cycle
  } mac_ctl_t;

endpackage

// ===== rtl/core/frc_cell.sv =====
// frc_cell: one tap of the filter, holding a sample and a kernel coefficient
`timescale 1ns / 1ps
module frc_cell
  import frc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctl_t                ctl_i,
  input  logic                     coef_we_i,
  input  logic signed [COEF_W-1:0] coef_value_i,
  input  logic signed [SMP_W-1:0]  sample_next_i,
  input  logic signed [COEF_W-1:0] coef_next_i,
  output logic signed [SMP_W-1:0]  sample_o,
  output logic signed [COEF_W-1:0] coef_o
);

  logic signed [SMP_W-1:0]  sample_q, sample_d;
  logic signed [COEF_W-1:0] coef_q, coef_d;

  always_comb begin
    sample_d = sample_q;
    coef_d   = coef_q;
    if (ctl_i.shift) begin
      sample_d = sample_next_i;
    end
    if (ctl_i.rotate) begin
      coef_d = coef_next_i;
    end else if (coef_we_i) begin
      coef_d = coef_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      coef_q   <= '0;
    end else begin
      sample_q <= sample_d;
      coef_q   <= coef_d;
    end
  end

  assign sample_o = sample_q;
  assign coef_o   = coef_q;

endmodule

// ===== rtl/core/frc_mac.sv =====
// frc_mac: shared multiply-accumulate at the head of the cell row, with floor shift and clamp
`timescale 1ns / 1ps
module frc_mac
  import frc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctl_t                 ctl_i,
  input  logic signed [SMP_W-1:0]  sample_i,
  input  logic signed [COEF_W-1:0] coef_i,
  output logic signed [SMP_W-1:0]  result_o,
  output logic                     saturated_o
);

  localparam int Q_W = ACC_W - FRAC_W;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [Q_W-1:0]    quot;
  logic [Q_W-SMP_W:0]       q_hi;

  // operands are sign extended first so the full product is kept
  assign prod_d = PROD_W'(sample_i) * PROD_W'(coef_i);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctl_i.mul_en;
      acc_q      <= acc_d;
    end
  end

  // arithmetic shift drops the fraction toward minus infinity
  assign quot = acc_q[ACC_W-1:FRAC_W];
  assign q_hi = quot[Q_W-1:SMP_W-1];

  always_comb begin
    saturated_o = !((&q_hi) || !(|q_hi));
    if (!saturated_o) begin
      result_o = quot[SMP_W-1:0];
    end else if (quot[Q_W-1]) begin
      result_o = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/core/fir_convolution_ring_filter.sv =====
// fir_convolution_ring_filter: fir filter over a row of tap cells with one shared mac
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | tvalid / tready         | tdata: sample_in, coef_index, coef_value; tuser: req_type
//  m_axis   | out | tvalid / tready         | tdata: filter_out; tuser: saturated
//
// a coefficient word is taken while idle and yields no result
// a sample word occupies the block while the cell row rotates once
//   past the single multiplier at its head, then a drain step empties the product
//   register and an emit step moves the clamped sum into the output register
// a held output word stalls only the final step; the next word is taken once it loads
// reset clears all samples, all coefficients and the control state
`timescale 1ns / 1ps
module fir_convolution_ring_filter
  import frc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [15:0] sample_in, [20:16] coef_index, [36:21] coef_value, [39:37] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] req_type
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [15:0] filter_out
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [0] saturated
  output logic                  m_axis_tuser_o
);

  frc_state_e state_q, state_d;
  logic [TAP_W-1:0] cnt_q, cnt_d;
  logic out_vld_q, out_vld_d;
  logic signed [SMP_W-1:0] out_data_q;
  logic out_sat_q;

  logic in_acc, smp_acc, coef_acc, cnt_last, out_free, out_load;
  logic signed [SMP_W-1:0]  in_sample;
  logic [IDX_W-1:0]         in_coef_index;
  logic signed [COEF_W-1:0] in_coef_value;

  cell_ctl_t cell_ctl;
  mac_ctl_t  mac_ctl;

  logic signed [SMP_W-1:0]  smp_row [TAPS];
  logic signed [COEF_W-1:0] coef_row [TAPS];

  logic signed [SMP_W-1:0] mac_result;
  logic                    mac_sat;

  assign in_sample     = s_axis_tdata_i[15:0];
  assign in_coef_index = s_axis_tdata_i[20:16];
  assign in_coef_value = s_axis_tdata_i[36:21];

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign smp_acc  = in_acc && (s_axis_tuser_i == REQ_SAMPLE);
  assign coef_acc = in_acc && (s_axis_tuser_i == REQ_COEF);
  assign cnt_last = (cnt_q == TAP_W'(TAPS - 1));
  assign out_free = !out_vld_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (smp_acc) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready_o = 1'b0;
    cell_ctl        = '0;
    mac_ctl         = '0;
    out_load        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cell_ctl.shift  = smp_acc;
        mac_ctl.clear   = smp_acc;
      end
      ST_RUN: begin
        cell_ctl.shift  = 1'b1;
        cell_ctl.rotate = 1'b1;
        mac_ctl.mul_en  = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // row of tap cells: cell 0 holds the oldest sample and kernel entry 0
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    logic signed [SMP_W-1:0]  smp_next;
    logic signed [COEF_W-1:0] coef_next;
    logic                     hit;

    if (i == TAPS - 1) begin : g_tail
      // push brings in the new sample, rotation wraps the head around
      assign smp_next  = (state_q == ST_IDLE) ? in_sample : smp_row[0];
      assign coef_next = coef_row[0];
    end else begin : g_body
      assign smp_next  = smp_row[i+1];
      assign coef_next = coef_row[i+1];
    end

    assign hit = coef_acc && (int'(in_coef_index) == i);

    frc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl),
      .coef_we_i    (hit),
      .coef_value_i (in_coef_value),
      .sample_next_i(smp_next),
      .coef_next_i  (coef_next),
      .sample_o     (smp_row[i]),
      .coef_o       (coef_row[i])
    );
  end

  frc_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mac_ctl),
    .sample_i   (smp_row[0]),
    .coef_i     (coef_row[0]),
    .result_o   (mac_result),
    .saturated_o(mac_sat)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= mac_result;
      out_sat_q  <= mac_sat;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sat_q;

  a_smp_starts_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |=> (state_q == ST_RUN) && (cnt_q == '0))
    else $error("sample word did not start a pass over the cells");

  a_coef_stays_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_acc |=> (state_q == ST_IDLE) && !$rose(m_axis_tvalid_o))
    else $error("coefficient word left idle or produced a word");

  a_run_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) && !cnt_last |=> (state_q == ST_RUN) &&
      (cnt_q == $past(cnt_q) + 1'b1))
    else $error("tap counter skipped during a pass");

  a_load_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == ST_EMIT)
    else $error("output word loaded outside the emit step");

  a_pass_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> $past(state_q) == ST_RUN && $past(cnt_last))
    else $error("drain entered before the row rotated fully");

endmodule
